@@ rtl/brb_pkg.sv @@
package brb_pkg;

    localparam int STORE_DEPTH = 2048;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int FLD_W       = 12;
    localparam int CMP_W       = (CNT_W > FLD_W) ? CNT_W + 1 : FLD_W + 1;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_PEEK   = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_POP    = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  write_byte;
        logic [10:0] peek_offset;
        logic [11:0] remove_amount;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        valid_res;
        logic [11:0] removed;
        logic [11:0] fill_count;
    } res_t;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [7:0]       wdata;
        logic [PTR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic        rd_use;
        logic        valid_res;
        logic [11:0] removed;
        logic [11:0] fill_count;
    } rsp_t;

endpackage

@@ rtl/byte_ring_buffer_peek_ack.sv @@
// channel   signals                 direction   accepted when
// request   start, req              in          start high and busy low
// result    done, res               out         done high, cannot be held off
// config    cfg_we, cfg_data        in          cfg_we high
//
// one request per cycle; its result appears with done in the next cycle
// the store read port is a registered read
// busy stays low; reset empties the ring and sets ring_size to 2048
// the receiver cannot stall, so nothing is held back
module byte_ring_buffer_peek_ack (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  brb_pkg::req_t req,
    output logic          done,
    output brb_pkg::res_t res,
    input  logic          cfg_we,
    input  logic [11:0]   cfg_data
);
    import brb_pkg::*;

    ram_req_t   ram_req;
    rsp_t       rsp_next;
    rsp_t       rsp_reg;
    logic       done_reg;
    logic [7:0] ram_q;
    logic       accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    brb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .ram_req  (ram_req),
        .rsp_next (rsp_next)
    );

    brb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done           = done_reg;
    assign res.read_data  = rsp_reg.rd_use ? ram_q : 8'd0;
    assign res.valid_res  = rsp_reg.valid_res;
    assign res.removed    = rsp_reg.removed;
    assign res.fill_count = rsp_reg.fill_count;

endmodule

@@ rtl/brb_ram.sv @@
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/brb_ctrl.sv @@
module brb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  brb_pkg::req_t     req,
    input  logic              cfg_we,
    input  logic [11:0]       cfg_data,
    output brb_pkg::ram_req_t ram_req,
    output brb_pkg::rsp_t     rsp_next
);
    import brb_pkg::*;

    logic [11:0]      ring_size_reg;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [CMP_W-1:0] sz;
    logic [CMP_W-1:0] held_w;
    logic [CMP_W-1:0] amount_w;
    logic [CMP_W-1:0] removed_w;

    function automatic logic [PTR_W-1:0] wrap_add(
        input logic [PTR_W-1:0] p,
        input logic [CMP_W-1:0] d,
        input logic [CMP_W-1:0] size
    );
        logic [CMP_W-1:0] q;
        q = CMP_W'(p) + d;
        if (q >= size)
        begin
            q = q - size;
        end
        if (q >= size)
        begin
            q = '0;
        end
        return q[PTR_W-1:0];
    endfunction

    // effective ring size
    always_comb
    begin
        if (ring_size_reg == 12'd0)
        begin
            sz = CMP_W'(1);
        end
        else if (CMP_W'(ring_size_reg) > CMP_W'(STORE_DEPTH))
        begin
            sz = CMP_W'(STORE_DEPTH);
        end
        else
        begin
            sz = CMP_W'(ring_size_reg);
        end
    end

    assign held_w    = CMP_W'(held_reg);
    assign amount_w  = CMP_W'(req.remove_amount);
    assign removed_w = (amount_w < held_w) ? amount_w : held_w;

    always_comb
    begin
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        held_next        = held_reg;
        ram_req.we       = 1'b0;
        ram_req.waddr    = wp_reg;
        ram_req.wdata    = req.write_byte;
        ram_req.raddr    = rp_reg;
        rsp_next.rd_use    = 1'b0;
        rsp_next.valid_res = 1'b0;
        rsp_next.removed   = 12'd0;
        case (req.action)
            ACT_WRITE:
            begin
                if (held_w < sz)
                begin
                    ram_req.we         = accept;
                    wp_next            = wrap_add(wp_reg, CMP_W'(1), sz);
                    held_next          = held_reg + CNT_W'(1);
                    rsp_next.valid_res = 1'b1;
                end
            end
            ACT_PEEK:
            begin
                ram_req.raddr = wrap_add(rp_reg, CMP_W'(req.peek_offset), sz);
                if (CMP_W'(req.peek_offset) < held_w)
                begin
                    rsp_next.rd_use    = 1'b1;
                    rsp_next.valid_res = 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                rp_next            = wrap_add(rp_reg, removed_w, sz);
                held_next          = held_reg - removed_w[CNT_W-1:0];
                rsp_next.removed   = removed_w[11:0];
                rsp_next.valid_res = 1'b1;
            end
            ACT_POP:
            begin
                if (held_reg != '0)
                begin
                    rp_next            = wrap_add(rp_reg, CMP_W'(1), sz);
                    held_next          = held_reg - CNT_W'(1);
                    rsp_next.rd_use    = 1'b1;
                    rsp_next.valid_res = 1'b1;
                end
            end
            default:
            begin
                rsp_next.valid_res = 1'b0;
            end
        endcase
        rsp_next.fill_count = 12'(held_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= 12'(STORE_DEPTH);
            wp_reg        <= '0;
            rp_reg        <= '0;
            held_reg      <= '0;
        end
        else if (cfg_we)
        begin
            ring_size_reg <= cfg_data;
            wp_reg        <= '0;
            rp_reg        <= '0;
            held_reg      <= '0;
        end
        else if (accept)
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            held_reg <= held_next;
        end
    end

endmodule

@@ rtl/brb_chk.sv @@
module brb_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input brb_pkg::req_t req,
    input logic          done,
    input brb_pkg::res_t res
);
    import brb_pkg::*;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("request without result");

    a_done_caused: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without request");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !res.valid_res) |-> (res.read_data == 8'd0 && res.removed == 12'd0))
        else $error("failed action carries data");

    a_remove_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(req.action) == ACT_REMOVE) |-> res.valid_res)
        else $error("remove reported failure");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (res.fill_count <= 12'(STORE_DEPTH) && res.removed <= 12'(STORE_DEPTH)))
        else $error("fill count out of range");

endmodule

bind byte_ring_buffer_peek_ack brb_chk u_brb_chk (.*);
